### rtl/sasi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sasi_pkg;

	localparam int DEFAULT_DEPTH = 64;
	localparam int ADDR_W        = 48;
	localparam int RIDX_W        = 6;
	localparam int CNT_OUT_W     = 7;
	localparam int STATUS_W      = 3;

	localparam logic [CNT_OUT_W-1:0] CAP_RESET = 7'd64;

	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_READ   = 1'b1;

	localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
	localparam logic [STATUS_W-1:0] ST_PRESENT   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
	localparam logic [STATUS_W-1:0] ST_READ_OK   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 3'd4;

	typedef struct packed {
		logic              mode;
		logic [ADDR_W-1:0] address;
		logic [RIDX_W-1:0] read_index;
	} sasi_cmd_t;

	typedef struct packed {
		logic [STATUS_W-1:0]  status;
		logic [CNT_OUT_W-1:0] entry_total;
		logic [CNT_OUT_W-1:0] position;
		logic [ADDR_W-1:0]    entry_value;
	} sasi_rsp_t;

	typedef enum logic [2:0] {
		SAS_IDLE,
		SAS_READ,
		SAS_PROBE,
		SAS_COMPARE,
		SAS_SHIFT,
		SAS_PLACE
	} sasi_state_t;

endpackage

`default_nettype wire

### rtl/sorted_address_set_insert.sv
`timescale 1ns / 1ps
`default_nettype none

// Sorted set of 48-bit device addresses, ascending, without duplicates.
// A command is taken when start is high and busy is low. A read command
// returns the entry at read_index; an insert command searches the table and
// either reports the address as present, reports the table full, or opens a
// slot by moving the tail up one place and writes the address there.
// Every command gives exactly one response, shown on rsp for one cycle with
// rsp_valid high; the receiver cannot stall, so nothing is held back.
// A refused insert or a read beyond the count responds in the cycle after
// the transfer and leaves busy low; a valid read reads the table memory,
// then responds from state READ. An insert runs a binary search over the
// table memory, each probe a read in PROBE and a compare in COMPARE, up to
// ceil(log2(count+1)) probes, then a final PROBE closes it; a present
// address responds from its matching COMPARE. Otherwise the tail moves at
// one entry per cycle, then PLACE writes the address and responds. The
// table memory allows one read and one write per cycle. Busy falls in the
// cycle that shows the response, so the next command can be taken there.
// Reset empties the table at once (the count is cleared, no memory sweep)
// and sets capacity_limit to 64. cfg_we writes capacity_limit; the limit
// applied is the smaller of it and TABLE_DEPTH.
module sorted_address_set_insert #(
	parameter int TABLE_DEPTH = sasi_pkg::DEFAULT_DEPTH
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  start,
	output logic                 busy,
	input  sasi_pkg::sasi_cmd_t  cmd,
	output logic                 rsp_valid,
	output sasi_pkg::sasi_rsp_t  rsp,
	input  wire                  cfg_we,
	input  wire [6:0]            cfg_wdata
);
	import sasi_pkg::*;

	localparam int IDX_W  = $clog2(TABLE_DEPTH);
	localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
	localparam int WIDE_W = (CNT_W > CNT_OUT_W) ? CNT_W : CNT_OUT_W;

	sasi_state_t state_q, state_d;

	logic [CNT_W-1:0]     cnt_q;
	logic [CNT_OUT_W-1:0] cap_q;
	logic [CNT_W-1:0]     lo_q, hi_q, k_q;
	logic [IDX_W-1:0]     mid_q;
	logic [ADDR_W-1:0]    addr_q;
	logic [RIDX_W-1:0]    ridx_q;
	logic                 wr_pend_s1;
	logic [IDX_W-1:0]     wr_addr_s1;
	logic                 rsp_valid_q;
	sasi_rsp_t            rsp_q;

	logic [ADDR_W-1:0] entries_mem [TABLE_DEPTH];
	logic [ADDR_W-1:0] mem_rd_q;

	logic              mem_re, mem_we;
	logic [IDX_W-1:0]  mem_raddr, mem_waddr;
	logic [ADDR_W-1:0] mem_wdata;
	logic              rsp_set;
	sasi_rsp_t         rsp_d;

	logic              accept;
	logic              ridx_ok, full;
	logic [CNT_W:0]    mid_sum;
	logic [IDX_W-1:0]  mid;
	logic [WIDE_W-1:0] cnt_w, cnt_inc_w, cap_w, ridx_w, lo_w, mid_w;

	assign accept    = start && !busy;
	assign cnt_w     = WIDE_W'(cnt_q);
	assign cnt_inc_w = cnt_w + WIDE_W'(1);
	assign cap_w     = WIDE_W'(cap_q);
	assign ridx_w    = WIDE_W'(cmd.read_index);
	assign lo_w      = WIDE_W'(lo_q);
	assign mid_w     = WIDE_W'(mid_q);
	assign ridx_ok   = ridx_w < cnt_w;
	assign full      = (cnt_w >= cap_w) || (cnt_q == CNT_W'(TABLE_DEPTH));
	assign mid_sum   = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid       = mid_sum[IDX_W:1];

	assign busy      = (state_q != SAS_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			SAS_IDLE: begin
				if (accept) begin
					if (cmd.mode == MODE_READ) begin
						if (ridx_ok) state_d = SAS_READ;
					end else if (!full) begin
						state_d = SAS_PROBE;
					end
				end
			end
			SAS_READ:    state_d = SAS_IDLE;
			SAS_PROBE:   state_d = (lo_q < hi_q) ? SAS_COMPARE : SAS_SHIFT;
			SAS_COMPARE: state_d = (mem_rd_q == addr_q) ? SAS_IDLE : SAS_PROBE;
			SAS_SHIFT:   state_d = (k_q > lo_q) ? SAS_SHIFT : SAS_PLACE;
			SAS_PLACE:   state_d = SAS_IDLE;
			default:     state_d = SAS_IDLE;
		endcase
	end

	// Memory controls and response
	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = mid;
		mem_we    = 1'b0;
		mem_waddr = wr_addr_s1;
		mem_wdata = mem_rd_q;
		rsp_set   = 1'b0;
		rsp_d     = '0;

		// A shift write lands in the cycle after its read.
		if (wr_pend_s1) begin
			mem_we = 1'b1;
		end

		unique case (state_q)
			SAS_IDLE: begin
				if (accept) begin
					if (cmd.mode == MODE_READ) begin
						if (ridx_ok) begin
							mem_re    = 1'b1;
							mem_raddr = IDX_W'(cmd.read_index);
						end else begin
							rsp_set           = 1'b1;
							rsp_d.status      = ST_BAD_INDEX;
							rsp_d.entry_total = cnt_w[CNT_OUT_W-1:0];
							rsp_d.position    = CNT_OUT_W'(cmd.read_index);
							rsp_d.entry_value = '0;
						end
					end else if (full) begin
						rsp_set           = 1'b1;
						rsp_d.status      = ST_FULL;
						rsp_d.entry_total = cnt_w[CNT_OUT_W-1:0];
						rsp_d.position    = '0;
						rsp_d.entry_value = cmd.address;
					end
				end
			end
			SAS_READ: begin
				rsp_set           = 1'b1;
				rsp_d.status      = ST_READ_OK;
				rsp_d.entry_total = cnt_w[CNT_OUT_W-1:0];
				rsp_d.position    = CNT_OUT_W'(ridx_q);
				rsp_d.entry_value = mem_rd_q;
			end
			SAS_PROBE: begin
				if (lo_q < hi_q) begin
					mem_re    = 1'b1;
					mem_raddr = mid;
				end
			end
			SAS_COMPARE: begin
				if (mem_rd_q == addr_q) begin
					rsp_set           = 1'b1;
					rsp_d.status      = ST_PRESENT;
					rsp_d.entry_total = cnt_w[CNT_OUT_W-1:0];
					rsp_d.position    = mid_w[CNT_OUT_W-1:0];
					rsp_d.entry_value = addr_q;
				end
			end
			SAS_SHIFT: begin
				if (k_q > lo_q) begin
					mem_re    = 1'b1;
					mem_raddr = IDX_W'(k_q - CNT_W'(1));
				end
			end
			SAS_PLACE: begin
				mem_we            = 1'b1;
				mem_waddr         = lo_q[IDX_W-1:0];
				mem_wdata         = addr_q;
				rsp_set           = 1'b1;
				rsp_d.status      = ST_INSERTED;
				rsp_d.entry_total = cnt_inc_w[CNT_OUT_W-1:0];
				rsp_d.position    = lo_w[CNT_OUT_W-1:0];
				rsp_d.entry_value = addr_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) entries_mem[mem_waddr] <= mem_wdata;
		if (mem_re) mem_rd_q <= entries_mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= SAS_IDLE;
			cnt_q       <= '0;
			cap_q       <= CAP_RESET;
			wr_pend_s1  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			rsp_valid_q <= rsp_set;
			if (cfg_we) cap_q <= cfg_wdata;
			if (state_q == SAS_PLACE) cnt_q <= cnt_q + CNT_W'(1);
			wr_pend_s1 <= (state_q == SAS_SHIFT) && (k_q > lo_q);
		end
	end

	// Payload and search registers
	always_ff @(posedge clk) begin
		if (rsp_set) rsp_q <= rsp_d;
		wr_addr_s1 <= k_q[IDX_W-1:0];
		unique case (state_q)
			SAS_IDLE: begin
				if (accept) begin
					addr_q <= cmd.address;
					ridx_q <= cmd.read_index;
					lo_q   <= '0;
					hi_q   <= cnt_q;
					k_q    <= cnt_q;
				end
			end
			SAS_PROBE: begin
				mid_q <= mid;
			end
			SAS_COMPARE: begin
				// Lower bound: the slot ends at the first entry not below the address.
				if (mem_rd_q < addr_q) begin
					lo_q <= CNT_W'(mid_q) + CNT_W'(1);
				end else begin
					hi_q <= CNT_W'(mid_q);
				end
			end
			SAS_SHIFT: begin
				if (k_q > lo_q) k_q <= k_q - CNT_W'(1);
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTHESIS
	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

	a_probe_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SAS_PROBE) |-> (lo_q <= hi_q))
		else $error("search bounds crossed");

	a_shift_above_slot: assert property (@(posedge clk) disable iff (!arst_n)
		wr_pend_s1 |-> (CNT_W'(wr_addr_s1) > lo_q))
		else $error("tail move writes at or below the insert slot");

	a_place_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SAS_PLACE) |=>
			(rsp_valid_q && (rsp_q.status == ST_INSERTED)
			&& (cnt_q == $past(cnt_q) + CNT_W'(1))))
		else $error("insert did not respond with a grown count");

	a_bad_read: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (cmd.mode == MODE_READ) && !ridx_ok) |=>
			(rsp_valid_q && (rsp_q.status == ST_BAD_INDEX) && !busy))
		else $error("read beyond count not answered at once");
`endif

endmodule

`default_nettype wire

### verif/sasi_checker.sv
`timescale 1ns / 1ps

module sasi_checker (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  start,
	input  wire                  busy,
	input  sasi_pkg::sasi_cmd_t  cmd,
	input  wire                  rsp_valid,
	input  sasi_pkg::sasi_rsp_t  rsp,
	input  wire                  cfg_we,
	input  wire [6:0]            cfg_wdata,
	output int                   mismatches,
	output int                   outstanding
);
	import sasi_pkg::*;

	localparam int DEPTH = DEFAULT_DEPTH;

	logic [ADDR_W-1:0]    set_table [DEPTH];
	int unsigned          set_count;
	logic [CNT_OUT_W-1:0] capacity_copy;
	sasi_rsp_t            pending_responses [$];
	sasi_rsp_t            oldest;

	initial mismatches = 0;

	// Works out the response to one command and applies it to the local copy of the set.
	function automatic sasi_rsp_t predict_response(input sasi_cmd_t c);
		sasi_rsp_t   r;
		int unsigned limit;
		int unsigned slot;
		bit          found;
		r.entry_value = c.address;
		r.position    = '0;
		if (c.mode == MODE_READ) begin
			r.position = CNT_OUT_W'(c.read_index);
			if (c.read_index < set_count) begin
				r.status      = ST_READ_OK;
				r.entry_value = set_table[c.read_index];
			end else begin
				r.status      = ST_BAD_INDEX;
				r.entry_value = '0;
			end
		end else begin
			limit = (capacity_copy < DEPTH) ? capacity_copy : DEPTH;
			// A full table refuses the insert before any search, even for a present address.
			if (set_count >= limit) begin
				r.status = ST_FULL;
			end else begin
				slot  = set_count;
				found = 1'b0;
				for (int k = 0; k < set_count; k++) begin
					if (set_table[k] == c.address) begin
						found = 1'b1;
						slot  = k;
						break;
					end
					if (set_table[k] > c.address) begin
						slot = k;
						break;
					end
				end
				r.position = CNT_OUT_W'(slot);
				if (found) begin
					r.status = ST_PRESENT;
				end else begin
					for (int k = set_count; k > slot; k--)
						set_table[k] = set_table[k-1];
					set_table[slot] = c.address;
					set_count++;
					r.status = ST_INSERTED;
				end
			end
		end
		r.entry_total = CNT_OUT_W'(set_count);
		return r;
	endfunction

	task automatic check_field(input string fname, input logic [ADDR_W-1:0] want,
			input logic [ADDR_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", fname, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_count     = 0;
			capacity_copy = CAP_RESET;
			pending_responses.delete();
			outstanding  <= 0;
		end else begin
			if (rsp_valid) begin
				if (pending_responses.size() == 0) begin
					$error("response with nothing outstanding: status %0d value %0h",
						rsp.status, rsp.entry_value);
					mismatches++;
				end else begin
					oldest = pending_responses.pop_front();
					check_field("status", ADDR_W'(oldest.status), ADDR_W'(rsp.status));
					check_field("entry_total", ADDR_W'(oldest.entry_total),
						ADDR_W'(rsp.entry_total));
					check_field("position", ADDR_W'(oldest.position), ADDR_W'(rsp.position));
					check_field("entry_value", oldest.entry_value, rsp.entry_value);
				end
			end
			if (cfg_we)
				capacity_copy = cfg_wdata;
			if (start && !busy)
				pending_responses.push_back(predict_response(cmd));
			outstanding <= pending_responses.size();
		end
	end

endmodule

### verif/tb.sv
`timescale 1ns / 1ps

module tb;
	import sasi_pkg::*;

	localparam int SETTLE_CYCLES  = 4;
	localparam int DRAIN_CYCLES   = 100;
	localparam int WATCHDOG_LIMIT = 2000;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	sasi_cmd_t   cmd;
	logic        rsp_valid;
	sasi_rsp_t   rsp;
	logic        cfg_we;
	logic [6:0]  cfg_wdata;
	int          mismatches;
	int          outstanding;
	int          idle_cycles;
	int          burst_left;
	logic [ADDR_W-1:0] sent_addresses [$];

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	sorted_address_set_insert dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	sasi_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.cmd         (cmd),
		.rsp_valid   (rsp_valid),
		.rsp         (rsp),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// Any cycle without a transfer in either direction counts towards the watchdog.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || rsp_valid)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		$display("sorted_address_set_insert regression: fail");
		$finish;
	end

	task automatic issue(input sasi_cmd_t c);
		int gap;
		if (burst_left > 0) begin
			gap = 0;
			burst_left--;
		end else begin
			gap = $urandom_range(0, 13);
			if ($urandom_range(0, 9) == 0)
				burst_left = $urandom_range(5, 15);
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd   <= c;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (c.mode == MODE_INSERT)
			sent_addresses.push_back(c.address);
	endtask

	task automatic insert_addr(input logic [ADDR_W-1:0] a);
		sasi_cmd_t c;
		c.mode       = MODE_INSERT;
		c.address    = a;
		c.read_index = RIDX_W'($urandom());
		issue(c);
	endtask

	task automatic read_slot(input logic [RIDX_W-1:0] i);
		sasi_cmd_t c;
		c.mode       = MODE_READ;
		c.address    = {16'($urandom()), 32'($urandom())};
		c.read_index = i;
		issue(c);
	endtask

	// The register may only change once the block has finished everything handed to it.
	task automatic write_capacity(input logic [6:0] v);
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0 || busy)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	function automatic sasi_cmd_t random_command();
		sasi_cmd_t         c;
		logic [15:0]       hi;
		logic [31:0]       lo;
		logic [ADDR_W-1:0] known;
		int                pick;
		hi   = 16'($urandom());
		lo   = $urandom();
		pick = $urandom_range(0, 19);
		c.address    = {hi, lo};
		c.read_index = RIDX_W'($urandom());
		c.mode       = (pick < 5) ? MODE_READ : MODE_INSERT;
		known = (sent_addresses.size() > 0) ?
			sent_addresses[$urandom_range(0, sent_addresses.size() - 1)] : '0;
		// Repeats and near neighbours of addresses sent earlier probe the comparison edges.
		if (pick >= 5 && pick < 10)
			c.address = known;
		else if (pick == 10)
			c.address = known + 1'b1;
		else if (pick == 11)
			c.address = known - 1'b1;
		else if (pick == 12)
			c.address = {hi[0] ? 8'hFF : 8'h00, hi[15:8], lo};
		return c;
	endfunction

	task automatic run_phase(input logic [6:0] cap, input int n);
		write_capacity(cap);
		repeat (n) issue(random_command());
	endtask

	initial begin
		arst_n     = 1'b0;
		start      = 1'b0;
		cmd        = '0;
		cfg_we     = 1'b0;
		cfg_wdata  = '0;
		burst_left = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty table, ordering by the first byte, duplicates at both ends.
		read_slot(6'd0);
		read_slot(6'd63);
		insert_addr(48'h0000_0000_0000);
		insert_addr(48'hFFFF_FFFF_FFFF);
		insert_addr(48'h0100_0000_0000);
		insert_addr(48'h00FF_FFFF_FFFF);
		insert_addr(48'h0000_0000_0000);
		insert_addr(48'hFFFF_FFFF_FFFF);
		insert_addr(48'h8000_0000_0001);
		for (int i = 0; i < 6; i++)
			read_slot(RIDX_W'(i));
		read_slot(6'd63);

		// Filling up to the limit, then a present address against a full table.
		write_capacity(7'd6);
		insert_addr(48'h7FFF_FFFF_FFFF);
		insert_addr(48'h0000_0000_0001);
		insert_addr(48'hFFFF_FFFF_FFFF);

		// A limit below the count keeps every stored entry readable.
		write_capacity(7'd2);
		insert_addr(48'h1234_5678_9ABC);
		read_slot(6'd5);
		write_capacity(7'd0);
		insert_addr(48'h0000_0000_0000);
		read_slot(6'd0);

		run_phase(7'd0, 60);
		run_phase(7'd20, 90);
		run_phase(7'd1, 40);
		run_phase(7'd40, 100);
		run_phase(7'($urandom_range(41, 63)), 100);
		run_phase(7'd64, 160);
		run_phase(7'($urandom_range(0, 64)), 100);

		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("sorted_address_set_insert regression: pass");
		else
			$display("sorted_address_set_insert regression: fail");
		$finish;
	end

endmodule

### sim.f
rtl/sasi_pkg.sv
rtl/sorted_address_set_insert.sv
verif/sasi_checker.sv
verif/tb.sv
